>>> sv/fmprc_pkg.sv
// Shared types and constants for the first-match packet rule classifier.
package fmprc_pkg;

	localparam int unsigned CFG_DATA_W = 7;

	localparam logic OP_CLASSIFY = 1'b0;
	localparam logic OP_WRITE    = 1'b1;

	localparam logic CFG_FILTER_ENABLE = 1'b0;
	localparam logic CFG_RULES_IN_USE  = 1'b1;

	localparam logic [7:0] PROTO_WILD = 8'd143;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;
	localparam logic [7:0] PROTO_ICMP = 8'd1;

	localparam logic [15:0] PORT_WILD  = 16'd0;
	localparam logic [15:0] PORT_ABOVE = 16'd1023;

	localparam logic [1:0] DIR_IN  = 2'd1;
	localparam logic [1:0] DIR_OUT = 2'd2;
	localparam logic [1:0] DIR_ANY = 2'd3;

	localparam logic [1:0] ACK_NO  = 2'd1;
	localparam logic [1:0] ACK_YES = 2'd2;
	localparam logic [1:0] ACK_ANY = 2'd3;

	localparam logic [7:0] LOOP_OCTET = 8'd127;

	localparam logic VERDICT_DROP   = 1'b0;
	localparam logic VERDICT_ACCEPT = 1'b1;

	localparam logic [2:0] REASON_RULE     = 3'd0;
	localparam logic [2:0] REASON_INACTIVE = 3'd1;
	localparam logic [2:0] REASON_XMAS     = 3'd2;
	localparam logic [2:0] REASON_NOMATCH  = 3'd3;
	localparam logic [2:0] REASON_LOOPBACK = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [5:0]  src_len;
		logic [31:0] dst_addr;
		logic [5:0]  dst_len;
		logic [7:0]  protocol;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [1:0]  direction;
		logic [1:0]  ack_mode;
		logic        action;
	} rule_t;

	typedef struct packed {
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic        ack;
	} key_t;

endpackage

>>> sv/fmprc_rule_match.sv
// Rule compare unit: checks one stored rule against the packet key.
module fmprc_rule_match (
	input  fmprc_pkg::rule_t rule,
	input  fmprc_pkg::key_t  key,
	output logic             hit
);
	import fmprc_pkg::*;

	function automatic logic addr_ok(input logic [31:0] raddr, input logic [5:0] rlen,
			input logic [31:0] paddr);
		logic [31:0] mask;
		mask = ~(32'hFFFF_FFFF >> rlen);
		return (raddr == 32'd0) || ((raddr & mask) == (paddr & mask));
	endfunction

	function automatic logic port_ok(input logic [15:0] rport, input logic [15:0] pport);
		return (rport == PORT_WILD) || ((rport == PORT_ABOVE) && (pport > PORT_ABOVE)) ||
			(rport == pport);
	endfunction

	logic       prot_ok;
	logic       ack_ok;
	logic       ports_ok;
	logic       out_view;
	logic       in_view;
	logic [1:0] key_ack;

	assign key_ack  = key.ack ? ACK_YES : ACK_NO;
	assign prot_ok  = (rule.protocol == PROTO_WILD) || (rule.protocol == key.protocol);
	assign ack_ok   = (rule.protocol != PROTO_TCP) || (rule.ack_mode == ACK_ANY) ||
		(rule.ack_mode == key_ack);
	assign ports_ok = port_ok(rule.sport, key.sport) &&
		port_ok(rule.dport, key.dport);
	assign out_view = ((rule.direction == DIR_OUT) || (rule.direction == DIR_ANY)) &&
		addr_ok(rule.src_addr, rule.src_len, key.src_addr) &&
		addr_ok(rule.dst_addr, rule.dst_len, key.dst_addr);
	assign in_view  = ((rule.direction == DIR_IN) || (rule.direction == DIR_ANY)) &&
		addr_ok(rule.dst_addr, rule.dst_len, key.src_addr) &&
		addr_ok(rule.src_addr, rule.src_len, key.dst_addr);
	assign hit      = prot_ok && ack_ok && ports_ok && (out_view || in_view);

endmodule

>>> sv/first_match_packet_rule_classifier_core.sv
// Top level of the first-match packet rule classifier.
//
// Command channel (cmd_valid / cmd_stall): a beat either writes one rule into a
// slot of the rule memory (operation write) or classifies one packet key.
// Result channel (res_valid / res_stall): one beat with verdict, reason and
// matched_slot for each classify beat; a write beat gives no result.
// A write beat leaves the block idle, and it is ready for the next beat at once.
// A classify beat that is settled by the enable, loopback or xmas checks, or
// that meets a rule count of zero, goes straight to the finish state and from
// there to the output register. Otherwise the rules are scanned in order, one
// rule per cycle through the single memory read port and the one compare unit;
// the scan stops at the first rule that hits or after the last rule in use, and
// its result then passes through the finish state to the output register.
// cmd_stall is high from a classify beat until its result moves to the
// output register; the next beat is taken while that result waits there.
// When the receiver holds res_stall, the result stays and a finished
// classification waits for the output register, holding cmd_stall high.
// Reset clears the enable and rule count and empties both channels; rule
// slots hold nothing defined until written and need no clearing pass.
module first_match_packet_rule_classifier_core #(
	parameter int unsigned RULE_SLOTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  logic                            operation,
	input  logic [5:0]                      slot,
	input  logic [7:0]                      protocol,
	input  logic [31:0]                     src_addr,
	input  logic [31:0]                     dst_addr,
	input  logic [15:0]                     sport,
	input  logic [15:0]                     dport,
	input  logic [3:0]                      tcp_flags,
	input  logic [1:0]                      direction,
	input  logic [1:0]                      ack_mode,
	input  logic [11:0]                     prefix_lengths,
	input  logic                            rule_action,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            verdict,
	output logic [2:0]                      reason,
	output logic [5:0]                      matched_slot,
	input  logic                            cfg_write,
	input  logic                            cfg_index,
	input  logic [fmprc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fmprc_pkg::*;

	localparam int unsigned AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int unsigned CW = $clog2(RULE_SLOTS + 1);
	localparam int unsigned LW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

	state_t state_q, state_d;

	logic                  filter_enable_q;
	logic [CFG_DATA_W-1:0] rules_in_use_q;

	rule_t mem_q [RULE_SLOTS];
	rule_t wr_rule;
	rule_t rule_s1;

	key_t key_d, key_q;

	logic [LW-1:0] limit_d, limit_q;
	logic [LW-1:0] idx_q;
	logic [LW-1:0] slot_s1;
	logic          valid_s1;
	logic          last_s1;

	logic cmd_accept;
	logic classify;
	logic wr_en;
	logic loopback;
	logic xmas;
	logic pre_done;
	logic pre_verdict;
	logic [2:0] pre_reason;
	logic hit;
	logic scan_end;
	logic issue;
	logic load_res;

	logic       pend_verdict_q;
	logic [2:0] pend_reason_q;
	logic [5:0] pend_slot_q;

	logic       res_valid_q;
	logic       verdict_q;
	logic [2:0] reason_q;
	logic [5:0] matched_slot_q;

	assign cmd_accept = cmd_valid && !cmd_stall;
	assign classify   = cmd_accept && (operation == OP_CLASSIFY);
	assign wr_en      = cmd_accept && (operation == OP_WRITE) && (32'(slot) < RULE_SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= 1'b0;
			rules_in_use_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_FILTER_ENABLE: filter_enable_q <= cfg_data[0];
				CFG_RULES_IN_USE:  rules_in_use_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		wr_rule.src_addr  = src_addr;
		wr_rule.src_len   = prefix_lengths[5:0];
		wr_rule.dst_addr  = dst_addr;
		wr_rule.dst_len   = prefix_lengths[11:6];
		wr_rule.protocol  = protocol;
		wr_rule.sport     = sport;
		wr_rule.dport     = dport;
		wr_rule.direction = direction;
		wr_rule.ack_mode  = ack_mode;
		wr_rule.action    = rule_action;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[AW'(slot)] <= wr_rule;
		end
		if (issue) begin
			rule_s1 <= mem_q[idx_q[AW-1:0]];
		end
	end

	always_comb begin
		key_d.protocol = protocol;
		key_d.src_addr = src_addr;
		key_d.dst_addr = dst_addr;
		key_d.ack      = (protocol == PROTO_TCP) && tcp_flags[0];
		if (protocol inside {PROTO_ICMP, PROTO_TCP, PROTO_UDP}) begin
			key_d.sport = sport;
			key_d.dport = dport;
		end else begin
			key_d.sport = '0;
			key_d.dport = '0;
		end
	end

	assign limit_d  = (LW'(rules_in_use_q) > LW'(RULE_SLOTS)) ? LW'(RULE_SLOTS)
		: LW'(rules_in_use_q);
	assign loopback = (src_addr[31:24] == LOOP_OCTET) && (dst_addr[31:24] == LOOP_OCTET);
	assign xmas     = (protocol == PROTO_TCP) && (tcp_flags[3:1] == 3'b111);
	assign pre_done = !filter_enable_q || loopback || xmas || (limit_d == '0);

	always_comb begin
		if (!filter_enable_q) begin
			pre_verdict = VERDICT_ACCEPT;
			pre_reason  = REASON_INACTIVE;
		end else if (loopback) begin
			pre_verdict = VERDICT_ACCEPT;
			pre_reason  = REASON_LOOPBACK;
		end else if (xmas) begin
			pre_verdict = VERDICT_DROP;
			pre_reason  = REASON_XMAS;
		end else begin
			pre_verdict = VERDICT_ACCEPT;
			pre_reason  = REASON_NOMATCH;
		end
	end

	fmprc_rule_match u_match (
		.rule (rule_s1),
		.key  (key_q),
		.hit  (hit)
	);

	assign scan_end = valid_s1 && (hit || last_s1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (classify) begin
					state_d = pre_done ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!res_valid_q || !res_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_stall = (state_q != ST_IDLE);
		issue     = (state_q == ST_SCAN) && (idx_q < limit_q) && !scan_end;
		load_res  = (state_q == ST_FINISH) && (!res_valid_q || !res_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			if (classify) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (classify) begin
			key_q   <= key_d;
			limit_q <= limit_d;
		end
		if (issue) begin
			slot_s1 <= idx_q;
			last_s1 <= ((idx_q + LW'(1)) == limit_q);
		end
		if (classify) begin
			pend_verdict_q <= pre_verdict;
			pend_reason_q  <= pre_reason;
			pend_slot_q    <= '0;
		end else if (valid_s1 && hit) begin
			pend_verdict_q <= rule_s1.action;
			pend_reason_q  <= REASON_RULE;
			pend_slot_q    <= slot_s1[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			verdict_q      <= pend_verdict_q;
			reason_q       <= pend_reason_q;
			matched_slot_q <= pend_slot_q;
		end
	end

	assign res_valid    = res_valid_q;
	assign verdict      = verdict_q;
	assign reason       = reason_q;
	assign matched_slot = matched_slot_q;

endmodule

>>> sv/fmprc_checker.sv
// Port-level checks for the classifier core, bound to the top level.
module fmprc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cmd_valid,
	input logic                            cmd_stall,
	input logic                            operation,
	input logic                            res_valid,
	input logic                            res_stall,
	input logic                            verdict,
	input logic [2:0]                      reason,
	input logic [5:0]                      matched_slot
);
	import fmprc_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(verdict) && $stable(reason) &&
			$stable(matched_slot))
		else $error("result beat changed while stalled");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (reason != REASON_RULE) |-> (matched_slot == 6'd0))
		else $error("matched_slot set without a rule match");

	a_reason_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (reason != REASON_RULE) |->
			((reason == REASON_XMAS) == (verdict == VERDICT_DROP)))
		else $error("verdict does not agree with reason");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && (operation == OP_WRITE) && !res_valid |=> !res_valid)
		else $error("write beat produced a result");

	a_classify_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && (operation == OP_CLASSIFY) |=> cmd_stall)
		else $error("command taken while classification in progress");

endmodule

bind first_match_packet_rule_classifier_core fmprc_checker u_checker (.*);
